// ===== design/pcaw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the angle-wrapping PID controller.
package pcaw_pkg;

  localparam int MeasW   = 24;  // measured sample and setpoint, 8 fraction bits
  localparam int GainW   = 24;  // Q11.12 gains
  localparam int OutW    = 16;  // drive value and output bounds
  localparam int ErrW    = 25;  // error, 8 fraction bits
  localparam int DiffW   = 26;  // error step for the derivative term
  localparam int ProdW   = 49;  // error times gain, 20 fraction bits
  localparam int DProdW  = 50;  // error step times gain
  localparam int IPartW  = 37;  // integral increment after the floor shift
  localparam int IntegW  = 40;  // integral accumulator, 8 fraction bits
  localparam int PdW     = 51;  // P plus D
  localparam int SumW    = 54;  // full controller sum, 20 fraction bits
  localparam int FracW   = 20;  // fraction bits of the sum
  localparam int IShiftW = 12;  // integral to sum alignment

  // Angle wrap: split the difference into whole degrees and 1/256 parts, then
  // reduce the degrees modulo 360 = 8 * 45, the 45 by reciprocal multiply.
  localparam int          WrapUW     = 15;
  localparam int          WrapProdW  = 31;
  localparam int          WrapShift  = 21;
  localparam logic [15:0] WrapOffset = 16'd8235;   // 183 * 45, keeps the operand positive
  localparam logic [15:0] WrapRecip  = 16'd46604;  // ceil(2^21 / 45)
  localparam logic [15:0] WrapMod    = 16'd45;
  localparam logic [16:0] HalfTurn   = 17'd46080;  // 180 degrees
  localparam logic signed [17:0] FullTurn = 18'sd92160;  // 360 degrees

  typedef enum logic [2:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_OUT_MIN    = 3'd4,
    REG_OUT_MAX    = 3'd5,
    REG_ANGLE_MODE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [MeasW-1:0] setpoint;
    logic signed [GainW-1:0] gain_p;
    logic signed [GainW-1:0] gain_i;
    logic signed [GainW-1:0] gain_d;
    logic signed [OutW-1:0]  out_min;
    logic signed [OutW-1:0]  out_max;
    logic                    angle_mode;
  } cfg_t;

  // Load strobes of the pipeline stages after the input register.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_ld_t;

endpackage

// ===== design/pcaw_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file of the angle-wrapping PID controller.
module pcaw_cfg
  import pcaw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [GainW-1:0]  cfg_wdata_i,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint   <= '0;
      cfg_q.gain_p     <= '0;
      cfg_q.gain_i     <= '0;
      cfg_q.gain_d     <= '0;
      cfg_q.out_min    <= {1'b1, {(OutW-1){1'b0}}};
      cfg_q.out_max    <= {1'b0, {(OutW-1){1'b1}}};
      cfg_q.angle_mode <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SETPOINT:   cfg_q.setpoint   <= cfg_wdata_i;
        REG_GAIN_P:     cfg_q.gain_p     <= cfg_wdata_i;
        REG_GAIN_I:     cfg_q.gain_i     <= cfg_wdata_i;
        REG_GAIN_D:     cfg_q.gain_d     <= cfg_wdata_i;
        REG_OUT_MIN:    cfg_q.out_min    <= cfg_wdata_i[OutW-1:0];
        REG_OUT_MAX:    cfg_q.out_max    <= cfg_wdata_i[OutW-1:0];
        REG_ANGLE_MODE: cfg_q.angle_mode <= cfg_wdata_i[0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/pcaw_err.sv =====
`timescale 1ns / 1ps
// Error former: plain difference or angle difference wrapped into (-180, 180].
module pcaw_err
  import pcaw_pkg::*;
(
  input  logic                    clk_i,
  input  stage_ld_t               ld_i,
  input  cfg_t                    cfg_i,
  input  logic signed [MeasW-1:0] meas_i,
  output logic signed [ErrW-1:0]  err_o
);

  // Stage 1: difference and reciprocal product
  logic signed [ErrW-1:0]  diff_d, diff_q;
  logic [15:0]             u1_ext;
  logic [WrapUW-1:0]       u1;
  logic [WrapProdW-1:0]    prod_d, prod_q;

  // Stage 2: remainder, wrap, mode select
  logic [15:0]             u2_ext;
  logic [9:0]              quot;
  logic [15:0]             rem_full;
  logic [6:0]              rem;
  logic [5:0]              rem45;
  logic [16:0]             turn_pos;
  logic signed [17:0]      wrapped;
  logic signed [ErrW-1:0]  err_d, err_q;

  assign diff_d = ErrW'(meas_i) - ErrW'(cfg_i.setpoint);

  // Whole degrees over 8, shifted positive by a multiple of 45
  assign u1_ext = {{2{diff_d[ErrW-1]}}, diff_d[ErrW-1:11]} + WrapOffset;
  assign u1     = u1_ext[WrapUW-1:0];
  assign prod_d = WrapProdW'(u1) * WrapProdW'(WrapRecip);

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      diff_q <= diff_d;
      prod_q <= prod_d;
    end
  end

  assign u2_ext   = {{2{diff_q[ErrW-1]}}, diff_q[ErrW-1:11]} + WrapOffset;
  assign quot     = prod_q[WrapShift +: 10];
  assign rem_full = u2_ext - 16'(quot) * WrapMod;
  assign rem      = rem_full[6:0];

  always_comb begin
    // one correction step covers any underestimate of the quotient
    if (rem >= 7'(WrapMod)) begin
      rem45 = 6'(rem - 7'(WrapMod));
    end else begin
      rem45 = rem[5:0];
    end
  end

  // Position within the turn in [0, 360) degrees, then fold the upper half down
  assign turn_pos = {rem45, diff_q[10:0]};
  assign wrapped  = (turn_pos > HalfTurn) ? $signed({1'b0, turn_pos}) - FullTurn
                                          : $signed({1'b0, turn_pos});

  assign err_d = cfg_i.angle_mode ? ErrW'(wrapped) : -diff_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      err_q <= err_d;
    end
  end

  assign err_o = err_q;

endmodule

// ===== design/pcaw_law.sv =====
`timescale 1ns / 1ps
// Control law: gain products, saturating integral, term sum and output clamp.
module pcaw_law
  import pcaw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stage_ld_t              ld_i,
  input  cfg_t                   cfg_i,
  input  logic signed [ErrW-1:0] err_i,
  output logic signed [OutW-1:0] drive_o
);

  // Stage 3: products
  logic signed [DiffW-1:0]  err_step;
  logic signed [ProdW-1:0]  p_d, p_q;
  logic signed [DProdW-1:0] dd_d, dd_q;
  logic signed [ProdW-1:0]  ip_full;
  logic signed [IPartW-1:0] ip_d, ip_q;
  logic signed [ErrW-1:0]   prev_err_q;

  // Stage 4: integral and P plus D
  logic signed [IntegW:0]   integ_sum;
  logic signed [IntegW-1:0] integ_d, integ_q;
  logic signed [PdW-1:0]    pd_d, pd_q;

  // Stage 5: full sum
  logic signed [IntegW+IShiftW-1:0] integ_scaled;
  logic signed [SumW-1:0]           sum_d, sum_q;

  // Clamp and truncation
  logic signed [SumW-1:0]       lo_scaled, hi_scaled;
  logic signed [SumW-FracW-1:0] sum_int;
  logic                         frac_nz;
  logic signed [SumW-FracW-1:0] trunc;

  assign err_step = DiffW'(err_i) - DiffW'(prev_err_q);
  assign p_d      = ProdW'(err_i) * ProdW'(cfg_i.gain_p);
  assign dd_d     = DProdW'(err_step) * DProdW'(cfg_i.gain_d);
  assign ip_full  = ProdW'(err_i) * ProdW'(cfg_i.gain_i);
  assign ip_d     = ip_full[ProdW-1:IShiftW];  // floor division by 4096

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      p_q  <= p_d;
      dd_q <= dd_d;
      ip_q <= ip_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
    end else if (ld_i.s3) begin
      prev_err_q <= err_i;
    end
  end

  assign integ_sum = (IntegW+1)'(integ_q) + (IntegW+1)'(ip_q);

  always_comb begin
    if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
      integ_d = {integ_sum[IntegW], {(IntegW-1){~integ_sum[IntegW]}}};
    end else begin
      integ_d = integ_sum[IntegW-1:0];
    end
  end

  assign pd_d = PdW'(p_q) + PdW'(dd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ld_i.s4) begin
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      pd_q <= pd_d;
    end
  end

  assign integ_scaled = {integ_q, {IShiftW{1'b0}}};
  assign sum_d        = SumW'(pd_q) + SumW'(integ_scaled);

  always_ff @(posedge clk_i) begin
    if (ld_i.s5) begin
      sum_q <= sum_d;
    end
  end

  assign lo_scaled = {{(SumW-FracW-OutW){cfg_i.out_min[OutW-1]}}, cfg_i.out_min,
                      {FracW{1'b0}}};
  assign hi_scaled = {{(SumW-FracW-OutW){cfg_i.out_max[OutW-1]}}, cfg_i.out_max,
                      {FracW{1'b0}}};
  assign sum_int   = sum_q[SumW-1:FracW];
  assign frac_nz   = |sum_q[FracW-1:0];
  // round toward zero: a negative sum with a fraction moves up by one
  assign trunc     = sum_int + (SumW-FracW)'(sum_q[SumW-1] & frac_nz);

  always_comb begin
    if (sum_q < lo_scaled) begin
      drive_o = cfg_i.out_min;
    end else if (sum_q > hi_scaled) begin
      drive_o = cfg_i.out_max;
    end else begin
      drive_o = trunc[OutW-1:0];
    end
  end

endmodule

// ===== design/pid_controller_angle_wrap.sv =====
`timescale 1ns / 1ps
// Top level of the PID controller with output clamp and optional angle wrap.
// An accepted input word passes the input register, stages 1 to 5 and the output register.
// Throughput: one word per cycle while the sink takes words; each stage holds one word and moves on when free.
// Reset (rst_ni low, asynchronous): empty the pipeline, zero the integral and the
// previous error, and return the registers to their defaults (clamp at full range).
module pid_controller_angle_wrap
  import pcaw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  // Configuration writes, taken whenever cfg_we_i is high
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [GainW-1:0]  cfg_wdata_i,

  // Measured samples
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // [23:0] measured_value

  // Drive values
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata    // [15:0] drive_value
);

  cfg_t                     cfg;
  stage_ld_t                ld;
  logic signed [ErrW-1:0]   err;
  logic signed [OutW-1:0]   drive_d;

  // Occupancy of stages 0 (input) to 6 (output register)
  logic [6:0]               vld_q;
  logic [6:0]               rdy;

  logic signed [MeasW-1:0]  meas_q;
  logic [OutW-1:0]          drive_q;

  pcaw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // A stage can take a word when it is empty or its own word moves on,
  // so a waiting result only holds back the stages that are full behind it.
  always_comb begin
    rdy[6] = ~vld_q[6] | m_axis_tready;
    for (int k = 5; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  // Stage loads: the word in the stage before advances into the stage
  assign ld.s1 = vld_q[0] & rdy[1];
  assign ld.s2 = vld_q[1] & rdy[2];
  assign ld.s3 = vld_q[2] & rdy[3];
  assign ld.s4 = vld_q[3] & rdy[4];
  assign ld.s5 = vld_q[4] & rdy[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k <= 6; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && rdy[0]) begin
      meas_q <= s_axis_tdata;
    end
  end

  // Stages 1 and 2: form the error
  pcaw_err u_err (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .cfg_i  (cfg),
    .meas_i (meas_q),
    .err_o  (err)
  );

  // Stages 3 to 5: gains, integral, sum; clamp ahead of the output register
  pcaw_law u_law (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (ld),
    .cfg_i   (cfg),
    .err_i   (err),
    .drive_o (drive_d)
  );

  // Output register: hold the drive word until the sink takes it
  always_ff @(posedge clk_i) begin
    if (vld_q[5] && rdy[6]) begin
      drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid = vld_q[6];
  assign m_axis_tdata  = drive_q;

endmodule
